### rtl/ccpm_pkg.sv
`default_nettype none

package ccpm_pkg;

    // Field widths fixed by the request and result formats.
    localparam int unsigned OP_W       = 2;
    localparam int unsigned LD_IDX_W   = 16;
    localparam int unsigned LD_VAL_W   = 17;
    localparam int unsigned COORD_W    = 10;
    localparam int unsigned POS_W      = 16;
    localparam int unsigned STATUS_W   = 2;

    // Depth of the command queue between the front and the back end.
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_W      = 1;
    localparam int unsigned QCNT_W      = 2;

    // Request operation codes.
    typedef enum logic [OP_W-1:0] {
        OP_LOAD_PERM = 2'd0,
        OP_LOAD_COL  = 2'd1,
        OP_LOAD_ROW  = 2'd2,
        OP_MAP       = 2'd3
    } t_op;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_MAPPED = 2'd0,
        ST_UPPER  = 2'd1,
        ST_MISS   = 2'd2
    } t_status;

    // Command kinds after classification in the front end.
    typedef enum logic [2:0] {
        KIND_NOP  = 3'd0,
        KIND_PERM = 3'd1,
        KIND_COL  = 3'd2,
        KIND_ROW  = 3'd3,
        KIND_MAP  = 3'd4,
        KIND_MISS = 3'd5
    } t_kind;

    typedef struct packed {
        t_op                 op;
        logic [LD_IDX_W-1:0] load_index;
        logic [LD_VAL_W-1:0] load_value;
        logic [COORD_W-1:0]  entry_row;
        logic [COORD_W-1:0]  entry_col;
        logic                entry_last;
    } t_req;

    typedef struct packed {
        logic [POS_W-1:0] position;
        t_status          status;
        logic             result_last;
    } t_rsp;

    typedef struct packed {
        t_kind               kind;
        logic [LD_IDX_W-1:0] load_index;
        logic [LD_VAL_W-1:0] load_value;
        logic [COORD_W-1:0]  entry_row;
        logic [COORD_W-1:0]  entry_col;
        logic                entry_last;
    } t_cmd;

endpackage

`default_nettype wire

### rtl/coo_to_csc_position_mapper.sv
`default_nettype none

// Maps sparse (row, col) entries to flat positions of a lower-triangular
// compressed-column pattern held in three internal tables, which load requests
// fill. A request is taken when start is high and busy is low; busy rises only
// when the front holding register and the two-entry command queue are full.
// Load requests give no result; each is written to its table as it leaves
// the queue. A map request reads the row and column permutations and the two
// column pointers, then runs a binary search of up to 17 steps (one more than
// the log2 of the column's range rounded down), each step being one read of
// the row-index memory; the result is registered. An entry above the diagonal
// is answered after the column-permutation read, an empty column range after
// the second column-pointer read, and a coordinate outside the table on
// leaving the queue. A result is shown for a single cycle with o_done high
// and cannot be held off by the receiver. The tables power up undefined: map
// only entries whose table slots have been loaded.
module coo_to_csc_position_mapper #(
    parameter int DIM_MAX     = 1024,
    parameter int PATTERN_MAX = 65536
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           start,
    input  wire ccpm_pkg::t_req i_req,
    output logic                busy,
    output logic                o_done,
    output ccpm_pkg::t_rsp      o_rsp
);
    import ccpm_pkg::*;

    logic q_full;
    logic q_empty;
    logic q_push;
    logic q_pop;
    t_cmd push_cmd;
    t_cmd head_cmd;

    // Front end: accepts and classifies requests.
    ccpm_front #(
        .DIM_MAX     (DIM_MAX),
        .PATTERN_MAX (PATTERN_MAX)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .i_req        (i_req),
        .busy         (busy),
        .i_queue_full (q_full),
        .o_push       (q_push),
        .o_cmd        (push_cmd)
    );

    // Command queue between the two ends.
    ccpm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (push_cmd),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (head_cmd)
    );

    // Back end: table writes, permutation, pointer fetch and search.
    ccpm_back #(
        .DIM_MAX     (DIM_MAX),
        .PATTERN_MAX (PATTERN_MAX)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (q_empty),
        .i_head  (head_cmd),
        .o_pop   (q_pop),
        .o_done  (o_done),
        .o_rsp   (o_rsp)
    );

endmodule

`default_nettype wire

### rtl/ccpm_front.sv
`default_nettype none

module ccpm_front #(
    parameter int DIM_MAX     = 1024,
    parameter int PATTERN_MAX = 65536
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           start,
    input  wire ccpm_pkg::t_req i_req,
    output logic                busy,
    input  wire logic           i_queue_full,
    output logic                o_push,
    output ccpm_pkg::t_cmd      o_cmd
);
    import ccpm_pkg::*;

    logic r_vld;
    logic n_vld;
    t_cmd r_cmd;
    t_cmd n_cmd;
    logic accept;

    // The holding register cannot move while the queue is full.
    assign busy   = r_vld && i_queue_full;
    assign accept = start && !busy;
    assign o_push = r_vld && !i_queue_full;
    assign o_cmd  = r_cmd;

    // Classify the request, drop loads whose slot or value is out of range and clamp
    // column starts to the pattern size.
    always_comb begin
        n_cmd.kind       = KIND_NOP;
        n_cmd.load_index = i_req.load_index;
        n_cmd.load_value = i_req.load_value;
        n_cmd.entry_row  = i_req.entry_row;
        n_cmd.entry_col  = i_req.entry_col;
        n_cmd.entry_last = i_req.entry_last;
        case (i_req.op)
            OP_LOAD_PERM: begin
                if (32'(i_req.load_index) < DIM_MAX && 32'(i_req.load_value) < DIM_MAX) begin
                    n_cmd.kind = KIND_PERM;
                end
            end
            OP_LOAD_COL: begin
                if (32'(i_req.load_index) < DIM_MAX + 1) begin
                    n_cmd.kind = KIND_COL;
                end
                if (32'(i_req.load_value) > PATTERN_MAX) begin
                    n_cmd.load_value = LD_VAL_W'(PATTERN_MAX);
                end
            end
            OP_LOAD_ROW: begin
                if (32'(i_req.load_index) < PATTERN_MAX && 32'(i_req.load_value) < DIM_MAX) begin
                    n_cmd.kind = KIND_ROW;
                end
            end
            OP_MAP: begin
                if (32'(i_req.entry_row) < DIM_MAX && 32'(i_req.entry_col) < DIM_MAX) begin
                    n_cmd.kind = KIND_MAP;
                end else begin
                    n_cmd.kind = KIND_MISS;
                end
            end
            default: begin
                n_cmd.kind = KIND_NOP;
            end
        endcase
    end

    // A new request enters the holding register unless it is a dropped load.
    always_comb begin
        n_vld = (accept && n_cmd.kind != KIND_NOP) || busy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
        if (accept) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

`default_nettype wire

### rtl/ccpm_queue.sv
`default_nettype none

module ccpm_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire ccpm_pkg::t_cmd i_cmd,
    input  wire logic           i_pop,
    output logic                o_full,
    output logic                o_empty,
    output ccpm_pkg::t_cmd      o_head
);
    import ccpm_pkg::*;

    t_cmd              r_slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_slot[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Slot storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

### rtl/ccpm_back.sv
`default_nettype none

module ccpm_back #(
    parameter int DIM_MAX     = 1024,
    parameter int PATTERN_MAX = 65536
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_empty,
    input  wire ccpm_pkg::t_cmd i_head,
    output logic                o_pop,
    output logic                o_done,
    output ccpm_pkg::t_rsp      o_rsp
);
    import ccpm_pkg::*;

    localparam int PERM_W = (DIM_MAX > 1) ? $clog2(DIM_MAX) : 1;
    localparam int PA_W   = PERM_W;
    localparam int CA_W   = $clog2(DIM_MAX + 1);
    localparam int RA_W   = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PERM_ROW,
        S_PERM_COL,
        S_COL_BEG,
        S_COL_END,
        S_SEARCH
    } t_state;

    // Table storage; reads are registered.
    logic [PERM_W-1:0]   perm_mem [DIM_MAX];
    logic [LD_VAL_W-1:0] col_mem  [DIM_MAX + 1];
    logic [PERM_W-1:0]   row_mem  [PATTERN_MAX];

    logic [PERM_W-1:0]   r_perm_q;
    logic [LD_VAL_W-1:0] r_col_q;
    logic [PERM_W-1:0]   r_row_q;

    logic [PA_W-1:0]     perm_raddr;
    logic [CA_W-1:0]     col_raddr;
    logic [RA_W-1:0]     row_raddr;
    logic                perm_we;
    logic                col_we;
    logic                row_we;

    t_state              r_state;
    t_state              n_state;
    t_cmd                r_cmd;
    t_cmd                n_cmd;
    logic [PERM_W-1:0]   r_r;
    logic [PERM_W-1:0]   n_r;
    logic [PERM_W-1:0]   r_c;
    logic [PERM_W-1:0]   n_c;
    logic [LD_VAL_W-1:0] r_beg;
    logic [LD_VAL_W-1:0] n_beg;
    logic [LD_VAL_W-1:0] r_lo;
    logic [LD_VAL_W-1:0] n_lo;
    logic [LD_VAL_W-1:0] r_hi;
    logic [LD_VAL_W-1:0] n_hi;
    logic [LD_VAL_W-1:0] r_mid;
    logic [LD_VAL_W-1:0] n_mid;
    logic                r_hi_eq;
    logic                n_hi_eq;
    logic                r_done;
    logic                n_done;
    t_rsp                r_rsp;
    t_rsp                n_rsp;

    function automatic logic [LD_VAL_W-1:0] mid_of(input logic [LD_VAL_W-1:0] lo,
                                                   input logic [LD_VAL_W-1:0] hi);
        logic [LD_VAL_W-1:0] span;
        span   = hi - lo;
        mid_of = lo + (span >> 1);
    endfunction

    assign o_pop   = (r_state == S_IDLE) && !i_empty;
    assign perm_we = o_pop && (i_head.kind == KIND_PERM);
    assign col_we  = o_pop && (i_head.kind == KIND_COL);
    assign row_we  = o_pop && (i_head.kind == KIND_ROW);
    assign o_done  = r_done;
    assign o_rsp   = r_rsp;

    // Read addresses: the row permutation is fetched while the item leaves the
    // queue, the column permutation in the cycle after.
    assign perm_raddr = (r_state == S_IDLE) ? PA_W'(i_head.entry_row) : PA_W'(r_cmd.entry_col);
    assign col_raddr  = (r_state == S_PERM_COL) ? CA_W'(r_perm_q) : CA_W'(r_c) + CA_W'(1);
    assign row_raddr  = RA_W'(n_mid);

    always_ff @(posedge i_clk) begin
        if (perm_we) begin
            perm_mem[PA_W'(i_head.load_index)] <= PERM_W'(i_head.load_value);
        end
        r_perm_q <= perm_mem[perm_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (col_we) begin
            col_mem[CA_W'(i_head.load_index)] <= i_head.load_value;
        end
        r_col_q <= col_mem[col_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (row_we) begin
            row_mem[RA_W'(i_head.load_index)] <= PERM_W'(i_head.load_value);
        end
        r_row_q <= row_mem[row_raddr];
    end

    // Sequencer: permute, fetch the column range, then a lower-bound search
    // that issues one row-index read per cycle.
    always_comb begin
        n_state      = r_state;
        n_cmd        = r_cmd;
        n_r          = r_r;
        n_c          = r_c;
        n_beg        = r_beg;
        n_lo         = r_lo;
        n_hi         = r_hi;
        n_hi_eq      = r_hi_eq;
        n_done       = 1'b0;
        n_rsp        = r_rsp;
        case (r_state)
            S_IDLE: begin
                if (o_pop) begin
                    n_cmd = i_head;
                    if (i_head.kind == KIND_MAP) begin
                        n_state = S_PERM_ROW;
                    end else if (i_head.kind == KIND_MISS) begin
                        n_done            = 1'b1;
                        n_rsp.position    = '0;
                        n_rsp.status      = ST_MISS;
                        n_rsp.result_last = i_head.entry_last;
                    end
                end
            end
            S_PERM_ROW: begin
                n_r     = r_perm_q;
                n_state = S_PERM_COL;
            end
            S_PERM_COL: begin
                if (r_r < r_perm_q) begin
                    n_done            = 1'b1;
                    n_rsp.position    = '0;
                    n_rsp.status      = ST_UPPER;
                    n_rsp.result_last = r_cmd.entry_last;
                    n_state           = S_IDLE;
                end else begin
                    n_c     = r_perm_q;
                    n_state = S_COL_BEG;
                end
            end
            S_COL_BEG: begin
                n_beg   = r_col_q;
                n_state = S_COL_END;
            end
            S_COL_END: begin
                if (r_beg >= r_col_q) begin
                    n_done            = 1'b1;
                    n_rsp.position    = '0;
                    n_rsp.status      = ST_MISS;
                    n_rsp.result_last = r_cmd.entry_last;
                    n_state           = S_IDLE;
                end else begin
                    n_lo    = r_beg;
                    n_hi    = r_col_q;
                    n_hi_eq = 1'b0;
                    n_state = S_SEARCH;
                end
            end
            S_SEARCH: begin
                if (r_row_q < r_r) begin
                    n_lo = r_mid + 1'b1;
                end else begin
                    n_hi    = r_mid;
                    n_hi_eq = (r_row_q == r_r);
                end
                if (n_lo >= n_hi) begin
                    // The upper bound is the found slot; it matches only if
                    // the entry read there equals the row.
                    n_done            = 1'b1;
                    n_rsp.position    = n_hi_eq ? POS_W'(n_hi) : '0;
                    n_rsp.status      = n_hi_eq ? ST_MAPPED : ST_MISS;
                    n_rsp.result_last = r_cmd.entry_last;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_mid = mid_of(n_lo, n_hi);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
        r_cmd   <= n_cmd;
        r_r     <= n_r;
        r_c     <= n_c;
        r_beg   <= n_beg;
        r_lo    <= n_lo;
        r_hi    <= n_hi;
        r_mid   <= n_mid;
        r_hi_eq <= n_hi_eq;
        r_rsp   <= n_rsp;
    end

endmodule

`default_nettype wire

### tb/tb_coo_to_csc_position_mapper.sv
`timescale 1ns / 100ps

module tb_coo_to_csc_position_mapper;
    import ccpm_pkg::*;

    localparam int DIM_MAX      = 1024;
    localparam int PATTERN_MAX  = 65536;
    localparam int VALUE_MAX    = 131071;
    localparam int ITEM_TARGET  = 750;
    localparam int DRAIN_CYCLES = 64;
    localparam longint TIMEOUT_NS = 4_000_000;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic start   = 1'b0;
    t_req i_req   = '0;
    logic busy;
    logic o_done;
    t_rsp o_rsp;

    // Shadow copy of the three lookup tables, with a written flag per slot.
    bit [9:0]  perm_tab     [DIM_MAX];
    bit        perm_valid   [DIM_MAX];
    bit [16:0] colptr_tab   [DIM_MAX+1];
    bit        colptr_valid [DIM_MAX+1];
    bit [9:0]  rowidx_tab   [PATTERN_MAX];
    bit        rowidx_valid [PATTERN_MAX];
    bit        read_unwritten;

    t_req pending_req_q[$];
    t_rsp expected_rsp_q[$];
    int   error_count    = 0;
    int   accepted_count = 0;
    int   item_total     = 0;
    int   stim_count     = 0;

    coo_to_csc_position_mapper u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_req   (i_req),
        .busy    (busy),
        .o_done  (o_done),
        .o_rsp   (o_rsp)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Table writes. Out-of-range slots and values are dropped, and column
    // starts saturate at the pattern size.
    function automatic void apply_load(t_req req);
        case (req.op)
            OP_LOAD_PERM: begin
                if (req.load_index < DIM_MAX && req.load_value < DIM_MAX) begin
                    perm_tab[req.load_index]   = req.load_value[9:0];
                    perm_valid[req.load_index] = 1'b1;
                end
            end
            OP_LOAD_COL: begin
                if (req.load_index <= DIM_MAX) begin
                    colptr_tab[req.load_index] = (req.load_value > PATTERN_MAX) ?
                                                 17'(PATTERN_MAX) : req.load_value;
                    colptr_valid[req.load_index] = 1'b1;
                end
            end
            OP_LOAD_ROW: begin
                if (req.load_value < DIM_MAX) begin
                    rowidx_tab[req.load_index]   = req.load_value[9:0];
                    rowidx_valid[req.load_index] = 1'b1;
                end
            end
            default: ;
        endcase
    endfunction

    // Permute the entry, then run a lower-bound search over the column's range.
    // Coordinates cannot exceed the table at these widths. Every slot the
    // hardware may touch is flagged if it was never written; the pointer pair
    // and the final landing slot are counted even where the answer ignores them.
    function automatic t_rsp lookup_entry(t_req req);
        t_rsp rsp;
        int   r;
        int   c;
        int   beg;
        int   fin;
        int   lo;
        int   hi;
        int   mid;
        rsp.position    = '0;
        rsp.status      = ST_MISS;
        rsp.result_last = req.entry_last;
        r = perm_tab[req.entry_row];
        c = perm_tab[req.entry_col];
        read_unwritten = !perm_valid[req.entry_row] || !perm_valid[req.entry_col] ||
                         !colptr_valid[c] || !colptr_valid[c+1];
        if (r < c) begin
            rsp.status = ST_UPPER;
            return rsp;
        end
        beg = colptr_tab[c];
        fin = colptr_tab[c+1];
        if (beg >= fin)
            return rsp;
        lo = beg;
        hi = fin;
        while (lo < hi) begin
            mid = lo + ((hi - lo) >> 1);
            read_unwritten |= !rowidx_valid[mid];
            if (rowidx_tab[mid] < r)
                lo = mid + 1;
            else
                hi = mid;
        end
        if (lo < PATTERN_MAX)
            read_unwritten |= !rowidx_valid[lo];
        if (lo < fin && rowidx_tab[lo] == r) begin
            rsp.position = lo[15:0];
            rsp.status   = ST_MAPPED;
        end
        return rsp;
    endfunction

    function automatic t_req make_req(t_op op, int idx, int val, int er, int ec, bit last);
        t_req req;
        req.op         = op;
        req.load_index = idx[15:0];
        req.load_value = val[16:0];
        req.entry_row  = er[9:0];
        req.entry_col  = ec[9:0];
        req.entry_last = last;
        return req;
    endfunction

    // Load request with random filler in the unused entry fields.
    function automatic t_req make_load(t_op op, int idx, int val);
        return make_req(op, idx, val, $urandom_range(0, DIM_MAX-1),
                        $urandom_range(0, DIM_MAX-1), 1'($urandom_range(0, 1)));
    endfunction

    function automatic void push_load(t_req req);
        apply_load(req);
        pending_req_q.push_back(req);
        stim_count++;
    endfunction

    // Map requests are queued only when no unwritten slot would be read.
    function automatic void push_map(int er, int ec, bit last);
        t_req req;
        req = make_req(OP_MAP, $urandom_range(0, 65535), $urandom_range(0, VALUE_MAX),
                       er, ec, last);
        void'(lookup_entry(req));
        if (!read_unwritten) begin
            pending_req_q.push_back(req);
            stim_count++;
        end
    endfunction

    // Load that the block must drop: slot or value out of range.
    function automatic t_req make_ignored_load();
        int sel;
        sel = $urandom_range(0, 2);
        if (sel == 0) begin
            if ($urandom_range(0, 1))
                return make_load(OP_LOAD_PERM, $urandom_range(DIM_MAX, 65535),
                                 $urandom_range(0, VALUE_MAX));
            return make_load(OP_LOAD_PERM, $urandom_range(0, DIM_MAX-1),
                             $urandom_range(DIM_MAX, VALUE_MAX));
        end
        if (sel == 1)
            return make_load(OP_LOAD_COL, $urandom_range(DIM_MAX+1, 65535),
                             $urandom_range(0, VALUE_MAX));
        return make_load(OP_LOAD_ROW, $urandom_range(0, 65535),
                         $urandom_range(DIM_MAX, VALUE_MAX));
    endfunction

    // One small lower-triangular pattern: a partial permutation onto a random
    // window, sorted row lists at a random offset, then map requests drawn
    // mostly from the pattern itself. Some columns lose their diagonal, some
    // are left unsorted, some get an empty or reversed range.
    task automatic build_pattern_set();
        int   n;
        int   base;
        int   offset;
        int   total;
        int   nmaps;
        int   pick;
        int   i;
        int   j;
        int   k;
        int   v;
        int   er;
        int   ec;
        bit   used[DIM_MAX];
        int   orig_of[$];
        int   rows_flat[$];
        int   col_first[$];
        int   ent_row[$];
        int   ent_col[$];
        t_req loads[$];
        t_req tmp;
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(11, 24) : $urandom_range(2, 10);
        base = $urandom_range(0, DIM_MAX - n);
        while (orig_of.size() < n) begin
            k = $urandom_range(0, DIM_MAX-1);
            if (!used[k]) begin
                used[k] = 1'b1;
                orig_of.push_back(k);
            end
        end

        // Row lists per column, diagonal usually present.
        for (j = 0; j < n; j++) begin
            col_first.push_back(rows_flat.size());
            for (i = j; i < n; i++) begin
                if ((i == j) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 1) == 1)) begin
                    rows_flat.push_back(base + i);
                    ent_row.push_back(i);
                    ent_col.push_back(j);
                end
            end
            k = rows_flat.size() - col_first[j];
            if (k >= 2 && $urandom_range(0, 9) == 0) begin
                v = rows_flat[col_first[j]];
                rows_flat[col_first[j]] = rows_flat[rows_flat.size()-1];
                rows_flat[rows_flat.size()-1] = v;
            end
        end
        total = rows_flat.size();
        col_first.push_back(total);
        if ($urandom_range(0, 5) == 0)
            offset = PATTERN_MAX - total;
        else
            offset = $urandom_range(0, PATTERN_MAX - 1 - total);

        for (j = 0; j < n; j++)
            loads.push_back(make_load(OP_LOAD_PERM, orig_of[j], base + j));
        for (j = 0; j <= n; j++) begin
            v = offset + col_first[j];
            if (j < n && $urandom_range(0, 11) == 0)
                v = offset + col_first[j+1] + $urandom_range(0, 1);
            if (v >= PATTERN_MAX && $urandom_range(0, 1))
                v = $urandom_range(PATTERN_MAX, VALUE_MAX);
            loads.push_back(make_load(OP_LOAD_COL, base + j, v));
        end
        for (k = 0; k < total; k++)
            loads.push_back(make_load(OP_LOAD_ROW, offset + k, rows_flat[k]));
        if (offset + total < PATTERN_MAX)
            loads.push_back(make_load(OP_LOAD_ROW, offset + total,
                                      $urandom_range(0, DIM_MAX-1)));

        // Shuffle the loads, sprinkling in requests that must be dropped.
        for (k = loads.size() - 1; k > 0; k--) begin
            i = $urandom_range(0, k);
            tmp = loads[k];
            loads[k] = loads[i];
            loads[i] = tmp;
        end
        foreach (loads[m]) begin
            if ($urandom_range(0, 7) == 0)
                pending_req_q.push_back(make_ignored_load());
            push_load(loads[m]);
        end

        nmaps = $urandom_range(2 * n, 4 * n);
        for (k = 0; k < nmaps; k++) begin
            pick = $urandom_range(0, 19);
            if (pick < 14 && ent_row.size() != 0) begin
                pick = $urandom_range(0, ent_row.size() - 1);
                er = orig_of[ent_row[pick]];
                ec = orig_of[ent_col[pick]];
            end else if (pick < 19) begin
                er = orig_of[$urandom_range(0, n-1)];
                ec = orig_of[$urandom_range(0, n-1)];
            end else begin
                er = $urandom_range(0, DIM_MAX-1);
                ec = $urandom_range(0, DIM_MAX-1);
            end
            push_map(er, ec, (k == nmaps - 1) || ($urandom_range(0, 15) == 0));
        end
    endtask

    task automatic clear_tables();
        int k;
        for (k = 0; k < DIM_MAX; k++) begin
            perm_tab[k]   = '0;
            perm_valid[k] = 1'b0;
        end
        for (k = 0; k <= DIM_MAX; k++) begin
            colptr_tab[k]   = '0;
            colptr_valid[k] = 1'b0;
        end
        for (k = 0; k < PATTERN_MAX; k++) begin
            rowidx_tab[k]   = '0;
            rowidx_valid[k] = 1'b0;
        end
    endtask

    // Request driver: on acceptance, update the shadow tables or record the
    // expected lookup result, then present the next request unless idling.
    always @(posedge i_clk) begin : drive_requests
        bit taken;
        int idle_pct;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            taken = start && !busy;
            if (taken) begin
                accepted_count++;
                if (i_req.op == OP_MAP)
                    expected_rsp_q.push_back(lookup_entry(i_req));
                else
                    apply_load(i_req);
            end
            if (taken || !start) begin
                if (accepted_count < item_total / 3)
                    idle_pct = 21;
                else if (accepted_count < 2 * item_total / 3)
                    idle_pct = 76;
                else
                    idle_pct = 0;
                if (pending_req_q.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
                    start <= 1'b1;
                    i_req <= pending_req_q.pop_front();
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Result monitor: every strobed result must match the oldest expectation.
    always @(posedge i_clk) begin : check_results
        t_rsp want;
        if (i_rst_n && o_done) begin
            if (expected_rsp_q.size() == 0) begin
                error_count++;
                $error("unexpected result: position %0d status %0d result_last %0d",
                       o_rsp.position, o_rsp.status, o_rsp.result_last);
            end else begin
                want = expected_rsp_q.pop_front();
                if (o_rsp.position !== want.position) begin
                    error_count++;
                    $error("position: expected %0d, got %0d", want.position, o_rsp.position);
                end
                if (o_rsp.status !== want.status) begin
                    error_count++;
                    $error("status: expected %0d, got %0d", want.status, o_rsp.status);
                end
                if (o_rsp.result_last !== want.result_last) begin
                    error_count++;
                    $error("result_last: expected %0d, got %0d",
                           want.result_last, o_rsp.result_last);
                end
            end
        end
    end

    initial begin
        clear_tables();

        // Directed: table extremes, dropped loads, saturated column start.
        push_load(make_load(OP_LOAD_PERM, 0, 0));
        push_load(make_load(OP_LOAD_PERM, DIM_MAX-1, DIM_MAX-1));
        pending_req_q.push_back(make_load(OP_LOAD_PERM, 65535, 5));
        pending_req_q.push_back(make_load(OP_LOAD_PERM, 7, DIM_MAX));
        pending_req_q.push_back(make_load(OP_LOAD_PERM, 8, VALUE_MAX));
        push_load(make_load(OP_LOAD_COL, 0, 0));
        push_load(make_load(OP_LOAD_COL, 1, 1));
        push_load(make_load(OP_LOAD_COL, DIM_MAX-1, PATTERN_MAX-1));
        push_load(make_load(OP_LOAD_COL, DIM_MAX, VALUE_MAX));
        pending_req_q.push_back(make_load(OP_LOAD_COL, DIM_MAX+1, 3));
        pending_req_q.push_back(make_load(OP_LOAD_COL, 65535, 0));
        push_load(make_load(OP_LOAD_ROW, 0, 0));
        push_load(make_load(OP_LOAD_ROW, 1, 5));
        push_load(make_load(OP_LOAD_ROW, PATTERN_MAX-1, DIM_MAX-1));
        pending_req_q.push_back(make_load(OP_LOAD_ROW, 2, DIM_MAX));
        pending_req_q.push_back(make_load(OP_LOAD_ROW, 3, VALUE_MAX));

        // Empty range on permuted column 1, reversed range on column 2.
        push_load(make_load(OP_LOAD_PERM, 512, 1));
        push_load(make_load(OP_LOAD_PERM, 300, 2));
        push_load(make_load(OP_LOAD_COL, 2, 1));
        push_load(make_load(OP_LOAD_COL, 3, 0));

        // Hit at the first slot, hit at the last slot, upper, search past end, empty and reversed range.
        push_map(0, 0, 1'b0);
        push_map(DIM_MAX-1, DIM_MAX-1, 1'b1);
        push_map(0, DIM_MAX-1, 1'b0);
        push_map(DIM_MAX-1, 0, 1'b0);
        push_map(512, 512, 1'b0);
        push_map(300, 300, 1'b1);

        while (stim_count < ITEM_TARGET)
            build_pattern_set();
        item_total = pending_req_q.size();
        clear_tables();

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait until every request has been taken and every result checked.
        while (accepted_count < item_total)
            @(posedge i_clk);
        while (expected_rsp_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0 && expected_rsp_q.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Watchdog for a hung handshake or lost results.
    initial begin
        #(TIMEOUT_NS);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
